@@ hdl/tlog_pkg.sv @@
// Shared types, constants and the vertex decode function of the thick line outline generator.
package tlog_pkg;

  // Fixed point format and limits.
  localparam int FRAC_BITS  = 8;
  localparam int MAX_DASHES = 13;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CRD_W      = 16;
  localparam int VTX_W      = 26;
  localparam int LEN_W      = 25;
  localparam int DEN_W      = 26;
  localparam int NUM_W      = 51;
  localparam int QUO_W      = 26;
  localparam int RES_W      = 27;
  localparam int SUM_W      = 29;
  localparam int T_W        = 17;
  localparam int RAD_W      = 50;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_SPACING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_START    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_END      = 3'd4;

  // Result status codes.
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_AXIS     = 2'd1;
  localparam logic [1:0] STS_TOO_MANY = 2'd2;

  // Path opcodes.
  localparam logic [1:0] OP_LINE   = 2'd0;
  localparam logic [1:0] OP_ARC    = 2'd1;
  localparam logic [1:0] OP_CENTRE = 2'd2;
  localparam logic [1:0] OP_CLOSE  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ1, ST_SQ2, ST_SQRT, ST_DIV_START, ST_DIV_WAIT, ST_CHECK, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DV_HX, DV_HY, DV_CNT, DV_OX1, DV_OY1, DV_OX2, DV_OY2
  } div_op_t;

  typedef enum logic [3:0] {
    VK_S_RIGHT, VK_S_CEN1, VK_S_BACK, VK_S_CEN2, VK_S_LEFT,
    VK_D1_LEFT, VK_D1_RIGHT, VK_D2_RIGHT, VK_D2_LEFT,
    VK_E_LEFT, VK_E_CEN1, VK_E_FRONT, VK_E_CEN2, VK_E_RIGHT,
    VK_REJ_AXIS, VK_REJ_DASH
  } vkind_t;

  typedef enum logic [1:0] { BS_START, BS_END, BS_DASH1, BS_DASH2 } base_t;

  typedef enum logic [2:0] { SD_CEN, SD_RIGHT, SD_LEFT, SD_BACK, SD_FRONT } side_t;

  typedef struct packed {
    logic [CFG_W-1:0] line_width;
    logic [CFG_W-1:0] dash_length;
    logic [CFG_W-1:0] dash_spacing;
    logic             cap_start;
    logic             cap_end;
  } cfg_t;

  typedef struct packed {
    logic    capture;
    logic    sq_mul;
    logic    sqrt_start;
    logic    div_start;
    div_op_t div_op;
    logic    tacc_adv;
    logic    out_load;
    vkind_t  out_kind;
  } cmd_t;

  typedef struct packed {
    logic       axis;
    logic       sqrt_busy;
    logic       div_busy;
    logic       dash_on;
    logic       too_many;
    logic [3:0] nd;
    logic       out_free;
  } sts_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] op;
    base_t      base;
    side_t      side;
    logic       last;
    logic       zero;
  } vdec_t;

  // Maps a vertex kind to its status, opcode, base point, offset direction and last and zero flags.
  function automatic vdec_t vtx_decode(vkind_t k, logic cap_s, logic cap_e);
    vdec_t d;
    d.status = STS_OK;
    d.op     = OP_LINE;
    d.base   = BS_START;
    d.side   = SD_CEN;
    d.last   = 1'b0;
    d.zero   = 1'b0;
    case (k)
      VK_S_RIGHT: begin d.side = SD_RIGHT; d.op = cap_s ? OP_ARC : OP_LINE; end
      VK_S_CEN1:  d.op = OP_CENTRE;
      VK_S_BACK:  begin d.side = SD_BACK; d.op = OP_ARC; end
      VK_S_CEN2:  d.op = OP_CENTRE;
      VK_S_LEFT:  d.side = SD_LEFT;
      VK_D1_LEFT: begin d.base = BS_DASH1; d.side = SD_LEFT; end
      VK_D1_RIGHT: begin d.base = BS_DASH1; d.side = SD_RIGHT; d.op = OP_CLOSE; end
      VK_D2_RIGHT: begin d.base = BS_DASH2; d.side = SD_RIGHT; end
      VK_D2_LEFT: begin d.base = BS_DASH2; d.side = SD_LEFT; end
      VK_E_LEFT: begin
        d.base = BS_END; d.side = SD_LEFT; d.op = cap_e ? OP_ARC : OP_LINE;
      end
      VK_E_CEN1:  begin d.base = BS_END; d.op = OP_CENTRE; end
      VK_E_FRONT: begin d.base = BS_END; d.side = SD_FRONT; d.op = OP_ARC; end
      VK_E_CEN2:  begin d.base = BS_END; d.op = OP_CENTRE; end
      VK_E_RIGHT: begin d.base = BS_END; d.side = SD_RIGHT; d.op = OP_CLOSE; d.last = 1'b1; end
      VK_REJ_AXIS: begin d.status = STS_AXIS; d.zero = 1'b1; d.last = 1'b1; end
      VK_REJ_DASH: begin d.status = STS_TOO_MANY; d.zero = 1'b1; d.last = 1'b1; end
      default: d.zero = 1'b1;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/tlog_ctrl.sv @@
// Controller state machine that sequences the square root, divisions and vertex emission.
`default_nettype none
module tlog_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  tlog_pkg::cfg_t   cfg,
  input  tlog_pkg::sts_t   sts,
  output logic             in_stall,
  output tlog_pkg::cmd_t   cmd
);
  import tlog_pkg::*;

  state_t     state_r, state_nxt;
  div_op_t    op_r, op_nxt;
  vkind_t     kind_r, kind_nxt;
  logic [3:0] j_r, j_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= DV_HX;
      kind_r  <= VK_S_RIGHT;
      j_r     <= 4'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      kind_r  <= kind_nxt;
      j_r     <= j_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    kind_nxt       = kind_r;
    j_nxt          = j_r;
    cmd            = '0;
    cmd.div_op     = op_r;
    cmd.out_kind   = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          j_nxt       = 4'd0;
          state_nxt   = ST_SQ1;
        end
      end
      ST_SQ1: begin
        if (sts.axis) begin
          kind_nxt  = VK_REJ_AXIS;
          state_nxt = ST_EMIT;
        end else begin
          cmd.sq_mul = 1'b1;
          state_nxt  = ST_SQ2;
        end
      end
      ST_SQ2: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_SQRT;
      end
      ST_SQRT: begin
        if (!sts.sqrt_busy) begin
          op_nxt    = DV_HX;
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = ST_DIV_START;
          case (op_r)
            DV_HX: op_nxt = DV_HY;
            DV_HY: begin
              if (sts.dash_on) begin
                op_nxt = DV_CNT;
              end else begin
                kind_nxt  = VK_S_RIGHT;
                state_nxt = ST_EMIT;
              end
            end
            DV_CNT: state_nxt = ST_CHECK;
            DV_OX1: op_nxt = DV_OY1;
            DV_OY1: op_nxt = DV_OX2;
            DV_OX2: op_nxt = DV_OY2;
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_CHECK: begin
        kind_nxt  = sts.too_many ? VK_REJ_DASH : VK_S_RIGHT;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          case (kind_r)
            VK_S_RIGHT: kind_nxt = cfg.cap_start ? VK_S_CEN1 : VK_S_LEFT;
            VK_S_CEN1:  kind_nxt = VK_S_BACK;
            VK_S_BACK:  kind_nxt = VK_S_CEN2;
            VK_S_CEN2:  kind_nxt = VK_S_LEFT;
            VK_S_LEFT: begin
              if (sts.nd != 4'd0) begin
                kind_nxt  = VK_D1_LEFT;
                op_nxt    = DV_OX1;
                state_nxt = ST_DIV_START;
              end else begin
                kind_nxt = VK_E_LEFT;
              end
            end
            VK_D1_LEFT:  kind_nxt = VK_D1_RIGHT;
            VK_D1_RIGHT: kind_nxt = VK_D2_RIGHT;
            VK_D2_RIGHT: kind_nxt = VK_D2_LEFT;
            VK_D2_LEFT: begin
              cmd.tacc_adv = 1'b1;
              j_nxt        = j_r + 4'd1;
              if ((j_r + 4'd1) < sts.nd) begin
                kind_nxt  = VK_D1_LEFT;
                op_nxt    = DV_OX1;
                state_nxt = ST_DIV_START;
              end else begin
                kind_nxt = VK_E_LEFT;
              end
            end
            VK_E_LEFT:  kind_nxt = cfg.cap_end ? VK_E_CEN1 : VK_E_RIGHT;
            VK_E_CEN1:  kind_nxt = VK_E_FRONT;
            VK_E_FRONT: kind_nxt = VK_E_CEN2;
            VK_E_CEN2:  kind_nxt = VK_E_RIGHT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/tlog_dp.sv @@
// Datapath: operand registers, iterative square root, iterative divider and output register.
`default_nettype none
module tlog_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  tlog_pkg::cfg_t                   cfg,
  input  tlog_pkg::cmd_t                   cmd,
  output tlog_pkg::sts_t                   sts,
  input  wire signed [tlog_pkg::CRD_W-1:0] in_start_x,
  input  wire signed [tlog_pkg::CRD_W-1:0] in_start_y,
  input  wire signed [tlog_pkg::CRD_W-1:0] in_end_x,
  input  wire signed [tlog_pkg::CRD_W-1:0] in_end_y,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [1:0]                       out_status,
  output logic [1:0]                       out_path_op,
  output logic signed [tlog_pkg::VTX_W-1:0] out_vertex_x,
  output logic signed [tlog_pkg::VTX_W-1:0] out_vertex_y,
  output logic                             out_last_vertex
);
  import tlog_pkg::*;

  // Segment registers.
  logic signed [CRD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [CRD_W:0]   dx, dy;
  logic [CRD_W-1:0]        adx, ady;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      ex_r <= in_end_x;
      ey_r <= in_end_y;
    end
  end

  assign dx  = {ex_r[CRD_W-1], ex_r} - {sx_r[CRD_W-1], sx_r};
  assign dy  = {ey_r[CRD_W-1], ey_r} - {sy_r[CRD_W-1], sy_r};
  assign adx = dx[CRD_W] ? CRD_W'(-dx) : dx[CRD_W-1:0];
  assign ady = dy[CRD_W] ? CRD_W'(-dy) : dy[CRD_W-1:0];

  // Square root, two radicand bits per cycle.
  logic [2*CRD_W:0]  sq_r;
  logic [RAD_W-1:0]  v_r, r_r, bit_r, rb;
  logic [4:0]        sq_cnt_r;
  logic              sqrt_busy_r, sq_ge;
  logic [LEN_W-1:0]  len_r;
  logic [RAD_W-1:0]  r_new;

  assign rb    = r_r + bit_r;
  assign sq_ge = (v_r >= rb);
  assign r_new = sq_ge ? ((r_r >> 1) + bit_r) : (r_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqrt_busy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sqrt_busy_r <= 1'b1;
    end else if (sqrt_busy_r && sq_cnt_r == 5'd24) begin
      sqrt_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) begin
      sq_r <= {1'b0, (2*CRD_W)'(adx) * (2*CRD_W)'(adx)};
    end
    if (cmd.sqrt_start) begin
      v_r      <= RAD_W'({(sq_r + {1'b0, (2*CRD_W)'(ady) * (2*CRD_W)'(ady)}),
                          {(2*FRAC_BITS){1'b0}}});
      r_r      <= '0;
      bit_r    <= RAD_W'(1) << (RAD_W - 2);
      sq_cnt_r <= 5'd0;
    end else if (sqrt_busy_r) begin
      if (sq_ge) begin
        v_r <= v_r - rb;
      end
      r_r      <= r_new;
      bit_r    <= bit_r >> 2;
      sq_cnt_r <= sq_cnt_r + 5'd1;
      if (sq_cnt_r == 5'd24) begin
        len_r <= (r_new[LEN_W-1:0] == '0) ? LEN_W'(1) : r_new[LEN_W-1:0];
      end
    end
  end

  // Dash period bookkeeping.
  logic [CFG_W:0]   per;
  logic [T_W-1:0]   tacc_r, t1, t2;
  logic             dash_on;

  assign per     = {1'b0, cfg.dash_length} + {1'b0, cfg.dash_spacing};
  assign t1      = tacc_r + T_W'(cfg.dash_length);
  assign t2      = tacc_r + T_W'(per);
  assign dash_on = (cfg.dash_length != '0) &&
                   ({4'd0, per, {FRAC_BITS{1'b0}}} < LEN_W'(len_r));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tacc_r <= '0;
    end else if (cmd.tacc_adv) begin
      tacc_r <= t2;
    end
  end

  // Divider operand selection and rounding bias.
  logic [CRD_W-1:0] mul_a;
  logic [T_W-1:0]   mul_b;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic             neg;

  always_comb begin
    mul_a = adx;
    mul_b = t1;
    neg   = dx[CRD_W];
    case (cmd.div_op)
      DV_HX:  begin mul_a = ady; mul_b = T_W'(cfg.line_width); neg = dy[CRD_W]; end
      DV_HY:  begin mul_a = adx; mul_b = T_W'(cfg.line_width); neg = dx[CRD_W]; end
      DV_OY1: begin mul_a = ady; neg = dy[CRD_W]; end
      DV_OX2: begin mul_b = t2; end
      DV_OY2: begin mul_a = ady; mul_b = t2; neg = dy[CRD_W]; end
      default: ;
    endcase
    case (cmd.div_op)
      DV_HX, DV_HY: begin
        den = {len_r, 1'b0};
        num = NUM_W'({(CRD_W+T_W)'(mul_a) * (CRD_W+T_W)'(mul_b),
                      {(2*FRAC_BITS){1'b0}}}) + NUM_W'(len_r);
      end
      DV_CNT: begin
        den = DEN_W'({per, {FRAC_BITS{1'b0}}});
        num = NUM_W'(len_r) + NUM_W'({(per - 13'd1), {FRAC_BITS{1'b0}}});
        neg = 1'b0;
      end
      default: begin
        den = DEN_W'(len_r);
        num = NUM_W'({(CRD_W+T_W)'(mul_a) * (CRD_W+T_W)'(mul_b),
                      {(2*FRAC_BITS){1'b0}}}) + NUM_W'(len_r >> 1);
      end
    endcase
  end

  // Restoring divider, one quotient bit per cycle.
  logic [DEN_W-1:0] rem_r, den_r;
  logic [QUO_W-1:0] qsh_r, quo;
  logic [DEN_W:0]   trial;
  logic             div_ge, neg_r, div_busy_r;
  logic [4:0]       dv_cnt_r;
  div_op_t          dv_op_r;
  logic [RES_W-1:0] res;
  logic signed [RES_W-1:0] hx_r, hy_r, ox1_r, oy1_r, ox2_r, oy2_r;
  logic [3:0]       nd_r;
  logic             too_many_r;

  assign trial  = {rem_r, qsh_r[QUO_W-1]};
  assign div_ge = (trial >= {1'b0, den_r});
  assign quo    = {qsh_r[QUO_W-2:0], div_ge};
  assign res    = neg_r ? RES_W'(-{1'b0, quo}) : {1'b0, quo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && dv_cnt_r == 5'(QUO_W - 1)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      nd_r       <= 4'd0;
      too_many_r <= 1'b0;
    end
    if (cmd.div_start) begin
      rem_r    <= DEN_W'(num[NUM_W-1:QUO_W]);
      qsh_r    <= num[QUO_W-1:0];
      den_r    <= den;
      neg_r    <= neg;
      dv_op_r  <= cmd.div_op;
      dv_cnt_r <= 5'd0;
    end else if (div_busy_r) begin
      rem_r    <= div_ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      qsh_r    <= quo;
      dv_cnt_r <= dv_cnt_r + 5'd1;
      if (dv_cnt_r == 5'(QUO_W - 1)) begin
        case (dv_op_r)
          DV_HX:  hx_r  <= res;
          DV_HY:  hy_r  <= res;
          DV_CNT: begin
            nd_r       <= quo[3:0];
            too_many_r <= (quo > QUO_W'(MAX_DASHES));
          end
          DV_OX1: ox1_r <= res;
          DV_OY1: oy1_r <= res;
          DV_OX2: ox2_r <= res;
          default: oy2_r <= res;
        endcase
      end
    end
  end

  // Vertex coordinate assembly and saturation.
  vdec_t dec;
  logic signed [SUM_W-1:0] bsx, bsy, bex, bey, bx, by, offx, offy, vx, vy;
  logic signed [SUM_W-1:0] hxe, hye;
  logic signed [VTX_W-1:0] satx, saty;

  function automatic logic signed [VTX_W-1:0] sat26(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] vmax, vmin;
    vmax = SUM_W'((1 <<< (VTX_W - 1)) - 1);
    vmin = -SUM_W'(1 <<< (VTX_W - 1));
    if (v > vmax) begin
      return vmax[VTX_W-1:0];
    end else if (v < vmin) begin
      return vmin[VTX_W-1:0];
    end
    return v[VTX_W-1:0];
  endfunction

  assign dec = vtx_decode(cmd.out_kind, cfg.cap_start, cfg.cap_end);
  assign bsx = SUM_W'($signed({sx_r, {FRAC_BITS{1'b0}}}));
  assign bsy = SUM_W'($signed({sy_r, {FRAC_BITS{1'b0}}}));
  assign bex = SUM_W'($signed({ex_r, {FRAC_BITS{1'b0}}}));
  assign bey = SUM_W'($signed({ey_r, {FRAC_BITS{1'b0}}}));
  assign hxe = SUM_W'(hx_r);
  assign hye = SUM_W'(hy_r);

  always_comb begin
    case (dec.base)
      BS_END:   begin bx = bex; by = bey; end
      BS_DASH1: begin bx = bsx + SUM_W'(ox1_r); by = bsy + SUM_W'(oy1_r); end
      BS_DASH2: begin bx = bsx + SUM_W'(ox2_r); by = bsy + SUM_W'(oy2_r); end
      default:  begin bx = bsx; by = bsy; end
    endcase
    case (dec.side)
      SD_RIGHT: begin offx = hxe;  offy = -hye; end
      SD_LEFT:  begin offx = -hxe; offy = hye;  end
      SD_BACK:  begin offx = -hye; offy = -hxe; end
      SD_FRONT: begin offx = hye;  offy = hxe;  end
      default:  begin offx = '0;   offy = '0;   end
    endcase
    vx   = bx + offx;
    vy   = by + offy;
    satx = dec.zero ? '0 : sat26(vx);
    saty = dec.zero ? '0 : sat26(vy);
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status      <= dec.status;
      out_path_op     <= dec.op;
      out_vertex_x    <= satx;
      out_vertex_y    <= saty;
      out_last_vertex <= dec.last;
    end
  end

  assign out_valid = out_valid_r;

  // Status to the controller.
  always_comb begin
    sts           = '0;
    sts.axis      = (sx_r == ex_r) || (sy_r == ey_r);
    sts.sqrt_busy = sqrt_busy_r;
    sts.div_busy  = div_busy_r;
    sts.dash_on   = dash_on;
    sts.too_many  = too_many_r;
    sts.nd        = nd_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // The two iterative units never run at once.
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sqrt_busy_r && div_busy_r))
    else $error("square root and divider busy together");

  // A division starts only on an idle divider and square root.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (!div_busy_r && !sqrt_busy_r))
    else $error("division started while a unit is busy");

  // A result is loaded only when the previous one has left or is leaving.
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output overwritten while stalled");

  // A loaded result is offered in the next cycle.
  a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not offered");

endmodule
`default_nettype wire

@@ hdl/thick_line_outline_generator.sv @@
// Top level of the thick line outline generator: configuration registers, controller and datapath.
//
// Usage: one request on the in_ channel is a line segment (two signed integer endpoints).
// The block answers with the vertex path of the segment's thick outline on the out_
// channel, one vertex per request, the final one flagged by out_last_vertex. A segment
// that is axis-aligned, or that needs more than thirteen dash periods, gets a single
// rejection request with a nonzero out_status instead.
// Timing: a new segment is taken only when the previous one is finished. The square
// root and the divisions run on iterative units, the divisions through the shared restoring
// divider; there are two divisions for the half-width offsets, one more for the dash count
// when dashing is on, and four per dash, those of each dash running before its vertices.
// Vertices otherwise leave one per cycle while out_stall is low.
// Reset (rst_n low, synchronous) returns the controller to idle, drops out_valid and
// restores the register reset values. A stall on the out_ channel holds the current
// vertex and pauses emission; the in_ channel is stalled while a segment is in work.
// Configuration writes on the cfg_ port take effect at once and belong to idle time.
`default_nettype none
module thick_line_outline_generator (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [tlog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tlog_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire signed [tlog_pkg::CRD_W-1:0] in_start_x,
  input  wire signed [tlog_pkg::CRD_W-1:0] in_start_y,
  input  wire signed [tlog_pkg::CRD_W-1:0] in_end_x,
  input  wire signed [tlog_pkg::CRD_W-1:0] in_end_y,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [1:0]                       out_status,
  output logic [1:0]                       out_path_op,
  output logic signed [tlog_pkg::VTX_W-1:0] out_vertex_x,
  output logic signed [tlog_pkg::VTX_W-1:0] out_vertex_y,
  output logic                             out_last_vertex
);
  import tlog_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width   <= CFG_W'(1);
      cfg_r.dash_length  <= '0;
      cfg_r.dash_spacing <= '0;
      cfg_r.cap_start    <= 1'b0;
      cfg_r.cap_end      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH:   cfg_r.line_width   <= cfg_wdata;
        REG_DASH_LENGTH:  cfg_r.dash_length  <= cfg_wdata;
        REG_DASH_SPACING: cfg_r.dash_spacing <= cfg_wdata;
        REG_CAP_START:    cfg_r.cap_start    <= cfg_wdata[0];
        REG_CAP_END:      cfg_r.cap_end      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tlog_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg      (cfg_r),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tlog_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_path_op     (out_path_op),
    .out_vertex_x    (out_vertex_x),
    .out_vertex_y    (out_vertex_y),
    .out_last_vertex (out_last_vertex)
  );

endmodule
`default_nettype wire

@@ sim/tlog_checker.sv @@
// Checker of the thick line outline generator: predicts every vertex and compares results.
module tlog_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [tlog_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [tlog_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire signed [tlog_pkg::CRD_W-1:0]   in_start_x,
  input  wire signed [tlog_pkg::CRD_W-1:0]   in_start_y,
  input  wire signed [tlog_pkg::CRD_W-1:0]   in_end_x,
  input  wire signed [tlog_pkg::CRD_W-1:0]   in_end_y,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire [1:0]                          out_status,
  input  wire [1:0]                          out_path_op,
  input  wire signed [tlog_pkg::VTX_W-1:0]   out_vertex_x,
  input  wire signed [tlog_pkg::VTX_W-1:0]   out_vertex_y,
  input  wire                                out_last_vertex,
  output int                                 n_fail,
  output int                                 n_pending
);
  import tlog_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]              status;
    logic [1:0]              op;
    logic signed [VTX_W-1:0] vx;
    logic signed [VTX_W-1:0] vy;
    logic                    last;
  } vertex_t;

  vertex_t vertex_q[$];

  logic [CFG_W-1:0] width_r, dlen_r, dgap_r;
  logic             cap_s_r, cap_e_r;

  assign n_pending = vertex_q.size();

  // Restoring integer square root.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Division rounded to nearest, ties away from zero.
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [VTX_W-1:0] clip26(longint v);
    if (v > 33554431) v = 33554431;
    if (v < -33554432) v = -33554432;
    return v[VTX_W-1:0];
  endfunction

  function automatic void push_vtx(logic [1:0] st, logic [1:0] op, longint x, longint y);
    vertex_t e;
    e.status = st;
    e.op = op;
    e.vx = clip26(x);
    e.vy = clip26(y);
    e.last = 1'b0;
    vertex_q.push_back(e);
  endfunction

  // Expected outline vertices of one segment.
  function automatic void predict_outline(longint sx, longint sy, longint ex, longint ey);
    longint dx, dy, hx, hy, p, len, nd, t1, t2, ox1, oy1, ox2, oy2;
    longint bsx, bsy, bex, bey;
    vertex_t e;
    nd = 0;
    if (sx == ex || sy == ey) begin
      push_vtx(STS_AXIS, OP_LINE, 0, 0);
    end else begin
      dx = ex - sx;
      dy = ey - sy;
      len = int_sqrt((dx * dx + dy * dy) << (2 * FRAC_BITS));
      if (len == 0) len = 1;
      hx = round_div(longint'(width_r) * dy * 65536, 2 * len);
      hy = round_div(longint'(width_r) * dx * 65536, 2 * len);
      p = longint'(dlen_r) + longint'(dgap_r);
      if (dlen_r != 0 && (p << FRAC_BITS) < len)
        nd = (len + ((p - 1) << FRAC_BITS)) / (p << FRAC_BITS);
      if (nd > MAX_DASHES) begin
        push_vtx(STS_TOO_MANY, OP_LINE, 0, 0);
      end else begin
        bsx = sx * 256; bsy = sy * 256; bex = ex * 256; bey = ey * 256;
        push_vtx(STS_OK, cap_s_r ? OP_ARC : OP_LINE, bsx + hx, bsy - hy);
        if (cap_s_r) begin
          push_vtx(STS_OK, OP_CENTRE, bsx, bsy);
          push_vtx(STS_OK, OP_ARC, bsx - hy, bsy - hx);
          push_vtx(STS_OK, OP_CENTRE, bsx, bsy);
        end
        push_vtx(STS_OK, OP_LINE, bsx - hx, bsy + hy);
        for (longint j = 0; j < nd; j++) begin
          t1 = j * p + longint'(dlen_r);
          t2 = (j + 1) * p;
          ox1 = round_div(dx * t1 * 65536, len);
          oy1 = round_div(dy * t1 * 65536, len);
          ox2 = round_div(dx * t2 * 65536, len);
          oy2 = round_div(dy * t2 * 65536, len);
          push_vtx(STS_OK, OP_LINE, bsx - hx + ox1, bsy + hy + oy1);
          push_vtx(STS_OK, OP_CLOSE, bsx + hx + ox1, bsy - hy + oy1);
          push_vtx(STS_OK, OP_LINE, bsx + hx + ox2, bsy - hy + oy2);
          push_vtx(STS_OK, OP_LINE, bsx - hx + ox2, bsy + hy + oy2);
        end
        push_vtx(STS_OK, cap_e_r ? OP_ARC : OP_LINE, bex - hx, bey + hy);
        if (cap_e_r) begin
          push_vtx(STS_OK, OP_CENTRE, bex, bey);
          push_vtx(STS_OK, OP_ARC, bex + hy, bey + hx);
          push_vtx(STS_OK, OP_CENTRE, bex, bey);
        end
        push_vtx(STS_OK, OP_CLOSE, bex + hx, bey - hy);
      end
    end
    e = vertex_q.pop_back();
    e.last = 1'b1;
    vertex_q.push_back(e);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: vertex %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    n_fail++;
  endtask

  // Register shadow, request prediction and result comparison.
  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      width_r <= 1;
      dlen_r  <= 0;
      dgap_r  <= 0;
      cap_s_r <= 0;
      cap_e_r <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_WIDTH:   width_r <= cfg_wdata;
          REG_DASH_LENGTH:  dlen_r  <= cfg_wdata;
          REG_DASH_SPACING: dgap_r  <= cfg_wdata;
          REG_CAP_START:    cap_s_r <= cfg_wdata[0];
          REG_CAP_END:      cap_e_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_outline(in_start_x, in_start_y, in_end_x, in_end_y);
      if (out_valid && !out_stall) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex request", $realtime);
          n_fail++;
        end else begin
          e = vertex_q.pop_front();
          if (out_status !== e.status) report_mismatch("status", out_status, e.status);
          if (out_path_op !== e.op) report_mismatch("path_op", out_path_op, e.op);
          if (out_vertex_x !== e.vx) report_mismatch("x", out_vertex_x, e.vx);
          if (out_vertex_y !== e.vy) report_mismatch("y", out_vertex_y, e.vy);
          if (out_last_vertex !== e.last) report_mismatch("last", out_last_vertex, e.last);
        end
      end
    end
  end

  initial n_fail = 0;
endmodule

@@ sim/tb_thick_line_outline_generator.sv @@
// Testbench top of the thick line outline generator: stimulus, register phases and verdict.
module tb_thick_line_outline_generator;
  import tlog_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 0, out_stall = 0;
  logic signed [CRD_W-1:0] in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  wire in_stall, out_valid, out_last_vertex;
  wire [1:0] out_status, out_path_op;
  wire signed [VTX_W-1:0] out_vertex_x, out_vertex_y;
  int n_fail, n_pending;
  int send_idle = 0, recv_idle = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  thick_line_outline_generator u_top (.*);

  tlog_checker u_check (.*);

  // Receiver stalls at the configured rate.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_style(int w, int dl, int ds, int cs, int ce);
    write_reg(REG_LINE_WIDTH, w);
    write_reg(REG_DASH_LENGTH, dl);
    write_reg(REG_DASH_SPACING, ds);
    write_reg(REG_CAP_START, cs);
    write_reg(REG_CAP_END, ce);
  endtask

  // Sends one segment; called at a falling edge and returns at the falling edge
  // after the request is taken, with in_valid still high.
  task automatic send_segment(int sx, int sy, int ex, int ey);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_start_x <= CRD_W'(sx); in_start_y <= CRD_W'(sy);
    in_end_x <= CRD_W'(ex); in_end_y <= CRD_W'(ey);
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (n_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Random segment, mostly short so dashes stay within the limit.
  task automatic send_random();
    int sx, sy, r;
    r = $urandom_range(99);
    sx = $signed(16'($urandom));
    sy = $signed(16'($urandom));
    if (r < 10)
      send_segment(sx, sy, $signed(16'($urandom)), $signed(16'($urandom)));
    else if (r < 15)
      send_segment(sx, sy, sx, $signed(16'($urandom)));
    else if (r < 20)
      send_segment(sx, sy, $signed(16'($urandom)), sy);
    else
      send_segment(sx, sy, 16'(sx + $urandom_range(400) - 200),
                   16'(sy + $urandom_range(400) - 200));
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1;
    // Directed: reset settings, extremes and axis cases, then fixed styles with caps and dashes.
    send_segment(0, 0, 3, 4);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(5, 5, 5, 9);
    send_segment(5, 5, 9, 5);
    send_segment(7, 7, 7, 7);
    drain();
    set_style(4095, 0, 0, 1, 1);
    send_segment(-32768, 32767, 32767, -32768);
    send_segment(1, 1, 2, 2);
    send_segment(10, -10, -20, 30);
    drain();
    set_style(0, 3, 2, 1, 0);
    send_segment(0, 0, 30, 40);
    send_segment(0, 0, 3, 4);
    send_segment(0, 0, 300, 400);
    drain();
    set_style(9, 4095, 4095, 0, 1);
    send_segment(0, 0, 30, 40);
    send_segment(-32768, -32768, 32767, 32767);
    drain();
    set_style(5, 1, 0, 1, 1);
    send_segment(0, 0, 6, 8);
    send_segment(0, 0, 7, 8);
    send_segment(0, 0, 60, 80);
    drain();
    // Random phases through the idling patterns and several styles.
    for (int ph = 0; ph < 12; ph++) begin
      send_idle = (ph < 4) ? 18 : (ph < 8) ? 84 : 0;
      recv_idle = (ph < 4) ? 84 : (ph < 8) ? 18 : 0;
      set_style($urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(40),
                $urandom_range(1) ? $urandom_range(60) : 0,
                $urandom_range(3) == 0 ? 4095 - $urandom_range(1) : $urandom_range(40),
                $urandom_range(1), $urandom_range(1));
      repeat (40) send_random();
      drain();
    end
    if (n_fail == 0)
      $display("tb_thick_line_outline_generator passed");
    else
      $display("tb_thick_line_outline_generator failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_thick_line_outline_generator failed");
    $finish;
  end
endmodule
